// ===== src/box_difference_regions_core_defines.svh =====
// Assertion macros shared by the checker of the box difference core.
`ifndef BOX_DIFFERENCE_REGIONS_CORE_DEFINES_SVH
`define BOX_DIFFERENCE_REGIONS_CORE_DEFINES_SVH

// A next-cycle implication that is switched off while reset is held.
`define BDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// A next-cycle implication that is also checked while reset is held.
`define BDR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/bdr_pkg.sv =====
// Types and constants shared by the box difference core.
`default_nettype none
package bdr_pkg;
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int WIDE_BITS  = COORD_BITS + 1;
    localparam int NUM_AXES   = 3;
    localparam int NUM_STEPS  = 2 * NUM_AXES;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
    localparam int AXIS_BITS  = $clog2(NUM_AXES);
    localparam int STEP_BITS  = $clog2(NUM_STEPS);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;

    typedef struct packed {
        t_coord new_min_x;
        t_coord new_min_y;
        t_coord new_min_z;
        t_size  new_size_x;
        t_size  new_size_y;
        t_size  new_size_z;
        t_coord old_min_x;
        t_coord old_min_y;
        t_coord old_min_z;
        t_size  old_size_x;
        t_size  old_size_y;
        t_size  old_size_z;
    } t_in_beat;

    typedef struct packed {
        t_coord region_min_x;
        t_coord region_min_y;
        t_coord region_min_z;
        t_size  region_size_x;
        t_size  region_size_y;
        t_size  region_size_z;
        logic   last_region;
    } t_out_beat;

    // Per axis: the original span [lo0, hi0) and the span left after both cuts [lo1, hi1).
    typedef struct packed {
        t_wide lo0;
        t_wide hi0;
        t_wide lo1;
        t_wide hi1;
    } t_axis;

    // Bit 2a is the slab below the old box on axis a, bit 2a+1 the slab above it.
    typedef struct packed {
        t_axis [NUM_AXES-1:0]  ax;
        logic  [NUM_STEPS-1:0] emit;
    } t_entry;

    typedef struct packed {
        logic   vld;
        t_entry entry;
    } t_qport;
endpackage
`default_nettype wire

// ===== src/bdr_front.sv =====
// Front part: takes input beats, forms the corners and works out which slabs exist.
`default_nettype none
module bdr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire bdr_pkg::t_in_beat i_data,
    input  wire logic             i_q_full,
    output bdr_pkg::t_qport       o_push
);
    import bdr_pkg::*;

    logic  r_s1_vld;
    logic  n_s1_vld;
    t_wide r_rlo [NUM_AXES];
    t_wide r_rhi [NUM_AXES];
    t_wide r_olo [NUM_AXES];
    t_wide r_ohi [NUM_AXES];
    t_coord in_nmin [NUM_AXES];
    t_size  in_nsize [NUM_AXES];
    t_coord in_omin [NUM_AXES];
    t_size  in_osize [NUM_AXES];
    t_entry entry;
    logic   s1_move;
    logic   s1_load;

    assign in_nmin  = '{i_data.new_min_x, i_data.new_min_y, i_data.new_min_z};
    assign in_nsize = '{i_data.new_size_x, i_data.new_size_y, i_data.new_size_z};
    assign in_omin  = '{i_data.old_min_x, i_data.old_min_y, i_data.old_min_z};
    assign in_osize = '{i_data.old_size_x, i_data.old_size_y, i_data.old_size_z};

    assign s1_move = r_s1_vld && ((entry.emit == '0) || !i_q_full);
    assign o_stall = r_s1_vld && !s1_move;
    assign s1_load = i_valid && !o_stall;
    assign n_s1_vld = s1_load || (r_s1_vld && !s1_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rlo[a] <= t_wide'({in_nmin[a][COORD_BITS-1], in_nmin[a]});
                r_rhi[a] <= t_wide'({in_nmin[a][COORD_BITS-1], in_nmin[a]})
                          + t_wide'({2'b00, in_nsize[a]});
                r_olo[a] <= t_wide'({in_omin[a][COORD_BITS-1], in_omin[a]});
                r_ohi[a] <= t_wide'({in_omin[a][COORD_BITS-1], in_omin[a]})
                          + t_wide'({2'b00, in_osize[a]});
            end
        end
    end

    always_comb begin
        logic go;
        logic go_a;
        logic c_lo;
        logic c_hi;
        t_wide lo1;
        t_wide hi1;
        go    = 1'b1;
        entry = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            c_lo = r_olo[a] > r_rlo[a];
            lo1  = c_lo ? ((r_rhi[a] < r_olo[a]) ? r_rhi[a] : r_olo[a]) : r_rlo[a];
            c_hi = r_ohi[a] < r_rhi[a];
            hi1  = c_hi ? ((lo1 > r_ohi[a]) ? lo1 : r_ohi[a]) : r_rhi[a];
            go_a = go && (r_rlo[a] < r_rhi[a]);
            entry.ax[a].lo0 = r_rlo[a];
            entry.ax[a].hi0 = r_rhi[a];
            entry.ax[a].lo1 = lo1;
            entry.ax[a].hi1 = hi1;
            entry.emit[2*a]   = go_a && c_lo;
            entry.emit[2*a+1] = go_a && c_hi;
            go = go_a && (lo1 < hi1);
        end
    end

    assign o_push.vld   = s1_move && (entry.emit != '0);
    assign o_push.entry = entry;
endmodule
`default_nettype wire

// ===== src/bdr_queue.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none
module bdr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bdr_pkg::t_qport i_push,
    output logic                o_full,
    output bdr_pkg::t_qport     o_head,
    input  wire logic           i_pop
);
    import bdr_pkg::*;

    t_entry                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wp;
    logic [Q_PTR_BITS-1:0] r_rp;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic [Q_CNT_BITS-1:0] n_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = r_cnt == Q_CNT_BITS'(Q_DEPTH);
    assign do_push = i_push.vld && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= (r_wp == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    assign o_head.vld   = r_cnt != '0;
    assign o_head.entry = r_mem[r_rp];
endmodule
`default_nettype wire

// ===== src/bdr_back.sv =====
// Back part: sends head item slabs via an output register, one per cycle unless stalled.
`default_nettype none
module bdr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bdr_pkg::t_qport i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output bdr_pkg::t_out_beat   o_data
);
    import bdr_pkg::*;

    logic [NUM_STEPS-1:0] r_done;
    logic [NUM_STEPS-1:0] n_done;
    logic                 r_out_vld;
    t_out_beat            r_out;
    t_out_beat            region;
    logic [NUM_STEPS-1:0] rem;
    logic [NUM_STEPS-1:0] pick;
    logic [STEP_BITS-1:0] step;
    logic                 last;
    logic                 adv;
    logic                 fire;

    assign rem  = i_head.entry.emit & ~r_done;
    assign adv  = !r_out_vld || !i_stall;
    assign fire = i_head.vld && adv;
    assign last = (rem & ~pick) == '0;
    assign o_pop = fire && last;
    assign n_done = (fire && !last) ? (r_done | pick) : (fire ? '0 : r_done);

    always_comb begin
        pick = '0;
        step = '0;
        for (int k = NUM_STEPS - 1; k >= 0; k--) begin
            if (rem[k]) begin
                pick = NUM_STEPS'(1) << k;
                step = STEP_BITS'(k);
            end
        end
    end

    always_comb begin
        logic [AXIS_BITS-1:0] sel;
        t_wide                lo [NUM_AXES];
        t_wide                hi [NUM_AXES];
        t_wide                diff [NUM_AXES];
        sel = step[STEP_BITS-1:1];
        for (int b = 0; b < NUM_AXES; b++) begin
            if (AXIS_BITS'(b) < sel) begin
                lo[b] = i_head.entry.ax[b].lo1;
                hi[b] = i_head.entry.ax[b].hi1;
            end else if (AXIS_BITS'(b) > sel) begin
                lo[b] = i_head.entry.ax[b].lo0;
                hi[b] = i_head.entry.ax[b].hi0;
            end else if (!step[0]) begin
                lo[b] = i_head.entry.ax[b].lo0;
                hi[b] = i_head.entry.ax[b].lo1;
            end else begin
                lo[b] = i_head.entry.ax[b].hi1;
                hi[b] = i_head.entry.ax[b].hi0;
            end
            diff[b] = hi[b] - lo[b];
        end
        region.region_min_x  = lo[0][COORD_BITS-1:0];
        region.region_min_y  = lo[1][COORD_BITS-1:0];
        region.region_min_z  = lo[2][COORD_BITS-1:0];
        region.region_size_x = diff[0][SIZE_BITS-1:0];
        region.region_size_y = diff[1][SIZE_BITS-1:0];
        region.region_size_z = diff[2][SIZE_BITS-1:0];
        region.last_region   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_done    <= '0;
        end else begin
            r_done <= n_done;
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (adv) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= region;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;
endmodule
`default_nettype wire

// ===== src/box_difference_regions_core.sv =====
// Top level of the box difference core: new box minus old box as disjoint slabs.
//
//   Channel   Signals                              Direction  Beat
//   input     i_in_valid, o_in_stall, i_in_data    in         one new box and one old box
//   output    o_out_valid, i_out_stall, o_out_data  out        one region, last one marked
//
// The back part sends one region per cycle unless the output stalls; an item has 1 to 6
// regions, as one with no region is never queued. An input beat passes the front
// register and the queue before the output register. Reset clears all valid and queue
// state. A stall on the output fills the two-entry queue and then stalls the input; the
// input keeps being taken while a region waits at the output.
`default_nettype none
module box_difference_regions_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bdr_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bdr_pkg::t_out_beat      o_out_data
);
    import bdr_pkg::*;

    t_qport push;
    t_qport head;
    logic   q_full;
    logic   pop;

    bdr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_data   (i_in_data),
        .i_q_full (q_full),
        .o_push   (push)
    );

    bdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    bdr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ===== src/bdr_checker.sv =====
// Port-level checks of the box difference core and their binding to the top level.
`default_nettype none
`include "box_difference_regions_core_defines.svh"
module bdr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire bdr_pkg::t_out_beat o_out_data
);
    import bdr_pkg::*;

`BDR_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
`BDR_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
`BDR_ASSERT_NEXT(a_item_continues, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_data.last_region, o_out_valid)
`BDR_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)
endmodule

bind box_difference_regions_core bdr_checker u_bdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
